// ===== rtl/bltb_pkg.sv =====
// Shared types, constants and a helper function for the byte-level unmapper.
`timescale 1ns / 1ps

package bltb_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // Sequence length codes returned by lead_len
   localparam logic [2:0] LenNone  = 3'd0;
   localparam logic [2:0] LenOne   = 3'd1;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } bltb_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_done;
   } bltb_rsp_type;

   // One scan job: up to four bytes, how many are valid, and end of text
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      cnt;
      logic            eot;
   } bltb_job_type;

   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      if (!c[7]) begin
         len = LenOne;
      end else if (c[7:5] == 3'b110) begin
         len = LenTwo;
      end else if (c[7:4] == 4'b1110) begin
         len = LenThree;
      end else if (c[7:3] == 5'b11110) begin
         len = LenFour;
      end else begin
         len = LenNone;
      end
      return len;
   endfunction

endpackage

// ===== rtl/bltb_front.sv =====
// Front end: accepts bytes, holds open sequences and issues scan jobs.
`timescale 1ns / 1ps

module bltb_front import bltb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bltb_req_type req_data,
   output logic         q_push,
   output bltb_job_type q_job,
   input  logic         q_full
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      hc_ff, hc_in;
   logic [2:0]      sl_ff, sl_in;

   logic       accept;
   logic [2:0] len;
   logic [2:0] n;
   logic       issue;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign len       = lead_len(req_data.data_byte);
   assign n         = {1'b0, hc_ff} + 3'd1;

   always_comb begin
      if (req_data.end_of_input) begin
         issue = 1'b1;
      end else if (hc_ff == 2'd0) begin
         issue = (len == LenNone) || (len == LenOne);
      end else begin
         issue = (n >= sl_ff);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q_job.bytes[k] = (hc_ff == 2'(k)) ? req_data.data_byte : held_ff[k];
      end
      q_job.bytes[3] = req_data.data_byte;
      q_job.cnt      = n;
      q_job.eot      = req_data.end_of_input;
   end

   assign q_push = accept && issue;

   always_comb begin
      held_in = held_ff;
      hc_in   = hc_ff;
      sl_in   = sl_ff;
      if (accept) begin
         if (issue) begin
            hc_in = 2'd0;
            sl_in = 3'd0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (hc_ff == 2'(k)) begin
                  held_in[k] = req_data.data_byte;
               end
            end
            hc_in = hc_ff + 2'd1;
            if (hc_ff == 2'd0) begin
               sl_in = len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         hc_ff <= 2'd0;
         sl_ff <= 3'd0;
      end else begin
         hc_ff <= hc_in;
         sl_ff <= sl_in;
      end
   end

`ifndef SYNTHESIS
   // an open sequence is always shorter than its length
   assert property (@(posedge clock) disable iff (reset)
      (hc_ff != 2'd0) |-> (sl_ff > {1'b0, hc_ff}))
      else $error("held count not below sequence length");

   assert property (@(posedge clock) disable iff (reset)
      (hc_ff == 2'd0) |-> (sl_ff == 3'd0))
      else $error("sequence length set with nothing held");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_input) |=> (hc_ff == 2'd0))
      else $error("state not cleared at end of text");
`endif

endmodule

// ===== rtl/bltb_queue.sv =====
// Small job queue between the front end and the scan engine.
`timescale 1ns / 1ps

module bltb_queue import bltb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bltb_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output bltb_job_type head_job
);

   bltb_job_type mem_ff [QueueDepth];

   logic [QueuePtrW-1:0] wr_ff, wr_in;
   logic [QueuePtrW-1:0] rd_ff, rd_in;
   logic [QueueCntW-1:0] cnt_ff, cnt_in;

   logic do_push, do_pop;

   assign full       = (cnt_ff == QueueCntW'(QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QueueCntW'(QueueDepth))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && cnt_ff != QueueCntW'(QueueDepth)) |-> (wr_ff != rd_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/bltb_back.sv =====
// Scan engine: walks a job, assembles code points and emits raw bytes.
`timescale 1ns / 1ps

module bltb_back import bltb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  bltb_job_type q_job,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bltb_rsp_type rsp_data
);

   // {hit, byte}
   function automatic logic [8:0] map_cp(input logic [20:0] cp);
      logic [8:0] r;
      logic [6:0] d;
      d = cp[6:0];
      r = '0;
      if (cp[20:8] == 13'd0) begin
         if ((cp[7:0] >= 8'd33 && cp[7:0] <= 8'd126) ||
             (cp[7:0] >= 8'd161 && cp[7:0] <= 8'd172) ||
             (cp[7:0] >= 8'd174)) begin
            r = {1'b1, cp[7:0]};
         end
      end else if (cp[20:8] == 13'd1 && cp[7:0] <= 8'd67) begin
         if (d <= 7'd32) begin
            r = {1'b1, 1'b0, d};
         end else if (d <= 7'd66) begin
            r = {1'b1, 8'({1'b0, d} + 8'd94)};
         end else begin
            r = {1'b1, 8'd173};
         end
      end
      return r;
   endfunction

   logic [1:0]   pos_ff, pos_in;
   logic [1:0]   raw_ff, raw_in;
   logic         rsp_valid_ff, rsp_valid_in;
   bltb_rsp_type rsp_ff, rsp_in;

   logic [3:0][7:0] win;
   logic [2:0]      len;
   logic [2:0]      rem;
   logic [20:0]     cp;
   logic [8:0]      mapped;
   logic [2:0]      step;
   logic [7:0]      emit_byte;
   logic [1:0]      raw_next;
   logic [2:0]      new_pos;
   logic            last;
   logic            go;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         win[k] = q_job.bytes[pos_ff + 2'(k)];
      end
   end

   assign len = lead_len(win[0]);
   assign rem = q_job.cnt - {1'b0, pos_ff};

   always_comb begin
      unique case (len)
         LenTwo:   cp = {10'd0, win[0][4:0], win[1][5:0]};
         LenThree: cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
         LenFour:  cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
         default:  cp = {13'd0, win[0]};
      endcase
   end

   assign mapped = map_cp(cp);

   always_comb begin
      step      = 3'd1;
      emit_byte = win[0];
      raw_next  = 2'd0;
      if (raw_ff != 2'd0) begin
         // tail of an unmapped sequence goes out as is
         raw_next = raw_ff - 2'd1;
      end else if (len == LenNone || len == LenOne || len > rem) begin
         step = 3'd1;
      end else if (mapped[8]) begin
         step      = len;
         emit_byte = mapped[7:0];
      end else begin
         raw_next = 2'(len - 3'd1);
      end
   end

   assign new_pos = {1'b0, pos_ff} + step;
   assign last    = (new_pos == q_job.cnt);
   assign go      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = go && last;

   always_comb begin
      pos_in       = pos_ff;
      raw_in       = raw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (go) begin
         pos_in             = last ? 2'd0 : new_pos[1:0];
         raw_in             = last ? 2'd0 : raw_next;
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = emit_byte;
         rsp_in.run_last    = last;
         rsp_in.text_done   = last && q_job.eot;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         pos_ff       <= 2'd0;
         raw_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      q_valid |-> ({1'b0, pos_ff} < q_job.cnt))
      else $error("scan position beyond job");

   assert property (@(posedge clock) disable iff (reset)
      (raw_ff != 2'd0) |-> (q_valid && pos_ff != 2'd0))
      else $error("raw tail pending without a job");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.text_done) |-> rsp_ff.run_last)
      else $error("text done without run last");
`endif

endmodule

// ===== rtl/byte_level_unicode_to_bytes_top.sv =====
// Top level of the byte-level code-point unmapper.
// Takes one text byte per cycle and returns the raw bytes behind the byte-level
// code-point mapping. The front end holds an open multibyte sequence and, once
// it completes or the text ends, hands up to four bytes as one job to a
// four-entry queue. The scan engine emits one result per cycle while the output
// is not stalled, and a job gives 1 to 4 results; since a job never yields more
// results than the bytes it took in, the sustained rate is one byte per cycle.
// Input stalls only while the queue is full; the output register can load a new
// result in the same cycle as its held result is taken. With nothing queued
// ahead, the first result of a job passes through the queue and then the output
// register once the byte that completes it is accepted.
`timescale 1ns / 1ps

module byte_level_unicode_to_bytes_top import bltb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bltb_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bltb_rsp_type rsp_data
);

   logic         push;
   bltb_job_type push_job;
   logic         full;
   logic         pop;
   logic         head_valid;
   bltb_job_type head_job;

   bltb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (push),
      .q_job     (push_job),
      .q_full    (full)
   );

   bltb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bltb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_job     (head_job),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
